FILE: src/fdrm_pkg.sv
`timescale 1ns / 1ps

package fdrm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE      = 2'd0;
    localparam logic [1:0] CFG_DIFF_THR  = 2'd1;
    localparam logic [1:0] CFG_LUMA_THR  = 2'd2;
    localparam logic [1:0] CFG_COLOUR    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0]  DIFF_THR_RESET = 8'd31;
    localparam logic [7:0]  LUMA_THR_RESET = 8'd95;
    localparam logic [23:0] COLOUR_RESET   = 24'h00FF00;

    // Opacity given by the hard modes.
    localparam logic [7:0] ALPHA_FULL = 8'd255;

    // Reciprocal of 3 scaled by 2^19; exact for every sum below 2^19.
    localparam logic [17:0] RECIP3       = 18'd174763;
    localparam int          RECIP3_SHIFT = 19;

    // Number of root bits, one cell per bit.
    localparam int ROOT_BITS = 8;

    typedef enum logic [1:0] {
        MODE_SOFT_NORMAL = 2'd0,
        MODE_HARD_NORMAL = 2'd1,
        MODE_SOFT_COLOUR = 2'd2,
        MODE_HARD_COLOUR = 2'd3
    } t_fdrm_mode;

    typedef struct packed {
        logic [7:0] prev_red;
        logic [7:0] prev_green;
        logic [7:0] prev_blue;
        logic [7:0] cur_red;
        logic [7:0] cur_green;
        logic [7:0] cur_blue;
    } t_fdrm_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_fdrm_out;

    // Word handed along the square-root cells.
    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  root;
        logic [7:0]  cur_red;
        logic [7:0]  cur_green;
        logic [7:0]  cur_blue;
        logic        luma_low;
    } t_fdrm_cell;

endpackage

FILE: src/fdrm_front.sv
`timescale 1ns / 1ps

module fdrm_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [7:0]            i_luma_thr,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fdrm_pkg::t_fdrm_in    i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fdrm_pkg::t_fdrm_cell  o_word
);

    // Stage one: squared channel differences and the luma test.
    logic        r_v1;
    logic [15:0] r_sq_r, r_sq_g, r_sq_b;
    logic [7:0]  r_c1_r, r_c1_g, r_c1_b;
    logic        r_luma1;
    // Stage two: sum of squares.
    logic        r_v2;
    logic [17:0] r_sum;
    logic [7:0]  r_c2_r, r_c2_g, r_c2_b;
    logic        r_luma2;
    // Stage three: sum divided by three.
    logic        r_v3;
    logic [15:0] r_quot;
    logic [7:0]  r_c3_r, r_c3_g, r_c3_b;
    logic        r_luma3;

    logic        w_adv1, w_adv2, w_adv3;
    logic [7:0]  w_d_r, w_d_g, w_d_b;
    logic [12:0] w_gray_sum;
    logic [7:0]  w_gray;
    logic [35:0] w_prod;

    // A stage moves on when it is empty or its successor moves on.
    assign w_adv3  = !r_v3 || i_ready;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;

    // Absolute channel differences.
    assign w_d_r = (i_word.prev_red > i_word.cur_red) ?
                   i_word.prev_red - i_word.cur_red : i_word.cur_red - i_word.prev_red;
    assign w_d_g = (i_word.prev_green > i_word.cur_green) ?
                   i_word.prev_green - i_word.cur_green :
                   i_word.cur_green - i_word.prev_green;
    assign w_d_b = (i_word.prev_blue > i_word.cur_blue) ?
                   i_word.prev_blue - i_word.cur_blue : i_word.cur_blue - i_word.prev_blue;

    // Gray of the current pixel, (11r + 16g + 5b) / 32.
    assign w_gray_sum = 13'(i_word.cur_red) * 13'd11 + {1'b0, i_word.cur_green, 4'b0000}
                      + 13'(i_word.cur_blue) * 13'd5;
    assign w_gray     = w_gray_sum[12:5];

    // Division by three through the scaled reciprocal.
    assign w_prod = 36'(r_sum) * 36'(fdrm_pkg::RECIP3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_sq_r  <= 16'(w_d_r) * 16'(w_d_r);
            r_sq_g  <= 16'(w_d_g) * 16'(w_d_g);
            r_sq_b  <= 16'(w_d_b) * 16'(w_d_b);
            r_c1_r  <= i_word.cur_red;
            r_c1_g  <= i_word.cur_green;
            r_c1_b  <= i_word.cur_blue;
            r_luma1 <= (w_gray < i_luma_thr);
        end
        if (w_adv2) begin
            r_sum   <= 18'(r_sq_r) + 18'(r_sq_g) + 18'(r_sq_b);
            r_c2_r  <= r_c1_r;
            r_c2_g  <= r_c1_g;
            r_c2_b  <= r_c1_b;
            r_luma2 <= r_luma1;
        end
        if (w_adv3) begin
            r_quot  <= w_prod[fdrm_pkg::RECIP3_SHIFT +: 16];
            r_c3_r  <= r_c2_r;
            r_c3_g  <= r_c2_g;
            r_c3_b  <= r_c2_b;
            r_luma3 <= r_luma2;
        end
    end

    assign o_valid          = r_v3;
    assign o_word.value     = r_quot;
    assign o_word.root      = 8'd0;
    assign o_word.cur_red   = r_c3_r;
    assign o_word.cur_green = r_c3_g;
    assign o_word.cur_blue  = r_c3_b;
    assign o_word.luma_low  = r_luma3;

endmodule

FILE: src/fdrm_root_cell.sv
`timescale 1ns / 1ps

module fdrm_root_cell #(
    parameter int BIT_POS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fdrm_pkg::t_fdrm_cell  i_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fdrm_pkg::t_fdrm_cell  o_word
);

    logic                  r_valid;
    fdrm_pkg::t_fdrm_cell  r_word;
    fdrm_pkg::t_fdrm_cell  n_word;
    logic                  w_adv;
    logic [7:0]            w_trial;
    logic [15:0]           w_trial_sq;

    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    // Try this cell's root bit and keep it if its square still fits.
    assign w_trial    = i_word.root | (8'd1 << BIT_POS);
    assign w_trial_sq = 16'(w_trial) * 16'(w_trial);

    always_comb begin
        n_word = i_word;
        if (w_trial_sq <= i_word.value) begin
            n_word.root = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: src/frame_difference_radiation_mask_top.sv
`timescale 1ns / 1ps

// Frame-difference motion mask. Each input word holds one pixel of the previous
// frame and the same pixel of the current frame; each output word gives the colour
// and alpha of the mask for that pixel. The block takes one word per clock unless
// the output stalls. Words pass three front stages (squared differences, their sum,
// division by three), a chain of eight cells that settle one square-root bit each,
// and the output register. Stages that hold no word keep accepting while the output
// is stalled. Configuration is written through a plain write port and is meant to
// change only while no word is in flight.

module frame_difference_radiation_mask_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [23:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fdrm_pkg::t_fdrm_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fdrm_pkg::t_fdrm_out  o_out_data
);

    localparam int NCELL = fdrm_pkg::ROOT_BITS;

    fdrm_pkg::t_fdrm_mode  r_mode;
    logic [7:0]            r_diff_thr;
    logic [7:0]            r_luma_thr;
    logic [23:0]           r_colour;

    logic                  w_valid [0:NCELL];
    logic                  w_ready [0:NCELL];
    fdrm_pkg::t_fdrm_cell  w_word  [0:NCELL];

    logic                  r_out_valid;
    fdrm_pkg::t_fdrm_out   r_out;
    fdrm_pkg::t_fdrm_out   n_out;
    fdrm_pkg::t_fdrm_cell  w_last;
    logic                  w_soft;
    logic                  w_normal;
    logic                  w_out_adv;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= fdrm_pkg::MODE_SOFT_NORMAL;
            r_diff_thr <= fdrm_pkg::DIFF_THR_RESET;
            r_luma_thr <= fdrm_pkg::LUMA_THR_RESET;
            r_colour   <= fdrm_pkg::COLOUR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fdrm_pkg::CFG_MODE:     r_mode     <= fdrm_pkg::t_fdrm_mode'(i_cfg_data[1:0]);
                fdrm_pkg::CFG_DIFF_THR: r_diff_thr <= i_cfg_data[7:0];
                fdrm_pkg::CFG_LUMA_THR: r_luma_thr <= i_cfg_data[7:0];
                fdrm_pkg::CFG_COLOUR:   r_colour   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front stages up to the quotient.
    fdrm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_luma_thr (r_luma_thr),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_word     (i_in_data),
        .o_valid    (w_valid[0]),
        .i_ready    (w_ready[0]),
        .o_word     (w_word[0])
    );

    // Square-root chain, most significant bit first.
    genvar k;
    generate
        for (k = 0; k < NCELL; k++) begin : g_cell
            fdrm_root_cell #(
                .BIT_POS (NCELL - 1 - k)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .o_ready (w_ready[k]),
                .i_word  (w_word[k]),
                .o_valid (w_valid[k+1]),
                .i_ready (w_ready[k+1]),
                .o_word  (w_word[k+1])
            );
        end
    endgenerate

    assign w_last    = w_word[NCELL];
    assign w_out_adv = !r_out_valid || i_out_ready;
    assign w_ready[NCELL] = w_out_adv;

    assign w_soft   = (r_mode == fdrm_pkg::MODE_SOFT_NORMAL) ||
                      (r_mode == fdrm_pkg::MODE_SOFT_COLOUR);
    assign w_normal = (r_mode == fdrm_pkg::MODE_SOFT_NORMAL) ||
                      (r_mode == fdrm_pkg::MODE_HARD_NORMAL);

    // Alpha from the root distance and the luma test; colour from the mode.
    always_comb begin
        if (w_last.luma_low || (w_last.root < r_diff_thr)) begin
            n_out.out_alpha = 8'd0;
        end else if (w_soft) begin
            n_out.out_alpha = w_last.root;
        end else begin
            n_out.out_alpha = fdrm_pkg::ALPHA_FULL;
        end
        if (w_normal) begin
            n_out.out_red   = w_last.cur_red;
            n_out.out_green = w_last.cur_green;
            n_out.out_blue  = w_last.cur_blue;
        end else begin
            n_out.out_red   = r_colour[23:16];
            n_out.out_green = r_colour[15:8];
            n_out.out_blue  = r_colour[7:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= w_valid[NCELL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
